// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the allocation table core.
// Define ASSERT_OFF to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication under an active-low reset.
`define BCAT_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under an active-low reset.
`define BCAT_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`else

`define BCAT_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define BCAT_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)

`endif

`endif

// ===== rtl/core/bcat_pkg.sv =====
`default_nettype none

package bcat_pkg;

    // Default geometry
    localparam int NUM_BLOCKS_DEF  = 256;
    localparam int BLOCK_BYTES_DEF = 512;

    // Entry markers
    localparam logic [15:0] EMPTY_MARK = 16'h0000;
    localparam logic [15:0] END_MARK   = 16'hFFFF;

    // Operation codes
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_LINK   = 2'd2;
    localparam logic [1:0] OP_LOCATE = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_CHAIN = 2'd2;

    // One request
    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] block;
        logic [15:0] next_value;
        logic [23:0] byte_offset;
        logic        extend;
    } req_t;

    // One response from the sequencer
    typedef struct packed {
        logic        valid;
        logic [15:0] result_block;
        logic [1:0]  status;
        logic [15:0] free_blocks;
    } resp_t;

    // Table port: one write and one read address per cycle
    typedef struct packed {
        logic        we;
        logic [15:0] waddr;
        logic [15:0] wdata;
        logic [15:0] raddr;
    } mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/bcat_table.sv =====
`default_nettype none

module bcat_table
    import bcat_pkg::*;
#(
    parameter int DEPTH  = NUM_BLOCKS_DEF,
    parameter int ADDR_W = $clog2(NUM_BLOCKS_DEF)
) (
    input  wire logic        clk,
    input  wire mem_req_t    mem_req,
    output logic [15:0]      rdata
);

    logic [15:0] next_mem [DEPTH];
    logic [15:0] rdata_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            next_mem[mem_req.waddr[ADDR_W-1:0]] <= mem_req.wdata;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rdata_reg <= next_mem[mem_req.raddr[ADDR_W-1:0]];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/bcat_ctrl.sv =====
`default_nettype none

module bcat_ctrl
    import bcat_pkg::*;
#(
    parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
    parameter int IDX_W       = $clog2(NUM_BLOCKS_DEF)
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire req_t        in_req,
    output mem_req_t         mem_req,
    input  wire logic [15:0] rdata,
    output resp_t            resp,
    input  wire logic        resp_ready
);

    localparam logic [15:0]      NB16      = 16'(NUM_BLOCKS);
    localparam logic [15:0]      MAX_FREE  = 16'(NUM_BLOCKS - 1);
    localparam logic [23:0]      BB24      = 24'(BLOCK_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_BLOCKS - 1);
    localparam logic [IDX_W-1:0] LAST_SCAN = IDX_W'(NUM_BLOCKS - 2);
    localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);

    typedef enum logic [10:0] {
        S_CLEAR    = 11'b000_0000_0001,
        S_IDLE     = 11'b000_0000_0010,
        S_FREE_CHK = 11'b000_0000_0100,
        S_FREE_RD  = 11'b000_0000_1000,
        S_LINK_RD  = 11'b000_0001_0000,
        S_LOC_CHK  = 11'b000_0010_0000,
        S_LOC_RD   = 11'b000_0100_0000,
        S_ALLOC    = 11'b000_1000_0000,
        S_SEEK1    = 11'b001_0000_0000,
        S_SEEK2    = 11'b010_0000_0000,
        S_RESP     = 11'b100_0000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [IDX_W-1:0] cursor_reg, cursor_next;
    logic [15:0]      count_reg, count_next;
    logic [15:0]      pos_reg, pos_next;
    logic [15:0]      nv_reg, nv_next;
    logic [23:0]      off_reg, off_next;
    logic             ext_reg, ext_next;
    logic             loc_mode_reg, loc_mode_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] scan_reg, scan_next;
    logic [IDX_W-1:0] got_reg, got_next;
    logic [IDX_W-1:0] after_reg, after_next;
    logic [15:0]      res_reg, res_next;
    logic [1:0]       status_reg, status_next;
    logic [IDX_W-1:0] idx_wrap;
    logic [IDX_W-1:0] cursor_end;

    // Step a scan index over 1..NUM_BLOCKS-1
    assign idx_wrap = (idx_reg == LAST_IDX) ? FIRST_IDX : idx_reg + FIRST_IDX;

    assign in_ready          = (state_reg == S_IDLE);
    assign resp.valid        = (state_reg == S_RESP);
    assign resp.result_block = res_reg;
    assign resp.status       = status_reg;
    assign resp.free_blocks  = count_reg;

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        cursor_next   = cursor_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        nv_next       = nv_reg;
        off_next      = off_reg;
        ext_next      = ext_reg;
        loc_mode_next = loc_mode_reg;
        idx_next      = idx_reg;
        scan_next     = scan_reg;
        got_next      = got_reg;
        after_next    = after_reg;
        res_next      = res_reg;
        status_next   = status_reg;
        cursor_end    = cursor_reg;
        mem_req       = '0;

        case (state_reg)
            // Sweep the table to its reset contents
            S_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = 16'(clr_reg);
                mem_req.wdata = (clr_reg == '0) ? END_MARK : EMPTY_MARK;
                clr_next      = clr_reg + FIRST_IDX;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end

            // Take a request and dispatch
            S_IDLE:
            begin
                mem_req.raddr = in_req.block;
                if (in_valid)
                begin
                    res_next      = END_MARK;
                    status_next   = ST_OK;
                    pos_next      = in_req.block;
                    nv_next       = in_req.next_value;
                    off_next      = in_req.byte_offset;
                    ext_next      = in_req.extend;
                    loc_mode_next = 1'b0;
                    case (in_req.operation)
                        OP_ALLOC:
                        begin
                            state_next = S_ALLOC;
                        end
                        OP_FREE:
                        begin
                            state_next = (in_req.block == EMPTY_MARK) ? S_RESP : S_FREE_CHK;
                        end
                        OP_LINK:
                        begin
                            if (in_req.block >= NB16)
                            begin
                                status_next = ST_CHAIN;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                state_next = S_LINK_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_LOC_CHK;
                        end
                    endcase
                end
            end

            // Check the next block of a chain being freed
            S_FREE_CHK:
            begin
                mem_req.raddr = pos_reg;
                if (pos_reg == END_MARK)
                begin
                    state_next = S_RESP;
                end
                else if (pos_reg == EMPTY_MARK || pos_reg >= NB16)
                begin
                    status_next = ST_CHAIN;
                    state_next  = S_RESP;
                end
                else
                begin
                    state_next = S_FREE_RD;
                end
            end

            // Empty the entry and follow its link, or stop on an empty entry
            S_FREE_RD:
            begin
                if (rdata == EMPTY_MARK)
                begin
                    status_next = ST_CHAIN;
                    state_next  = S_RESP;
                end
                else
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = pos_reg;
                    mem_req.wdata = EMPTY_MARK;
                    count_next    = count_reg + 16'd1;
                    pos_next      = rdata;
                    state_next    = S_FREE_CHK;
                end
            end

            // Write one entry and keep the free count
            S_LINK_RD:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg;
                mem_req.wdata = nv_reg;
                if (pos_reg != EMPTY_MARK)
                begin
                    if (rdata == EMPTY_MARK && nv_reg != EMPTY_MARK)
                    begin
                        count_next = count_reg - 16'd1;
                    end
                    else if (rdata != EMPTY_MARK && nv_reg == EMPTY_MARK)
                    begin
                        count_next = count_reg + 16'd1;
                    end
                end
                state_next = S_RESP;
            end

            // Range check on the block being walked
            S_LOC_CHK:
            begin
                mem_req.raddr = pos_reg;
                if (pos_reg >= NB16)
                begin
                    res_next    = END_MARK;
                    status_next = ST_CHAIN;
                    state_next  = S_RESP;
                end
                else
                begin
                    state_next = S_LOC_RD;
                end
            end

            // Stop, step along or extend the chain
            S_LOC_RD:
            begin
                if (rdata == EMPTY_MARK)
                begin
                    res_next    = END_MARK;
                    status_next = ST_CHAIN;
                    state_next  = S_RESP;
                end
                else if (off_reg < BB24)
                begin
                    res_next   = pos_reg;
                    state_next = S_RESP;
                end
                else if (rdata == END_MARK)
                begin
                    if (ext_reg)
                    begin
                        loc_mode_next = 1'b1;
                        state_next    = S_ALLOC;
                    end
                    else
                    begin
                        res_next    = END_MARK;
                        status_next = ST_CHAIN;
                        state_next  = S_RESP;
                    end
                end
                else
                begin
                    pos_next   = rdata;
                    off_next   = off_reg - BB24;
                    state_next = S_LOC_CHK;
                end
            end

            // Start the search at the free cursor, or report full if no block is free
            S_ALLOC:
            begin
                mem_req.raddr = 16'(cursor_reg);
                idx_next      = cursor_reg;
                scan_next     = '0;
                if (count_reg == 16'd0)
                begin
                    res_next    = END_MARK;
                    status_next = ST_FULL;
                    state_next  = S_RESP;
                end
                else
                begin
                    state_next = S_SEEK1;
                end
            end

            // Search for the entry to take
            S_SEEK1:
            begin
                if (rdata == EMPTY_MARK)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = 16'(idx_reg);
                    mem_req.wdata = END_MARK;
                    mem_req.raddr = 16'(idx_wrap);
                    count_next    = count_reg - 16'd1;
                    got_next      = idx_reg;
                    after_next    = idx_wrap;
                    idx_next      = idx_wrap;
                    scan_next     = '0;
                    state_next    = S_SEEK2;
                end
                else if (scan_reg == LAST_SCAN)
                begin
                    res_next    = END_MARK;
                    status_next = ST_FULL;
                    state_next  = S_RESP;
                end
                else
                begin
                    mem_req.raddr = 16'(idx_wrap);
                    idx_next      = idx_wrap;
                    scan_next     = scan_reg + FIRST_IDX;
                end
            end

            // Search for the next cursor, then hand the block back or link it into the chain being located
            S_SEEK2:
            begin
                mem_req.raddr = 16'(idx_wrap);
                if (rdata == EMPTY_MARK || scan_reg == LAST_SCAN)
                begin
                    cursor_end  = (rdata == EMPTY_MARK) ? idx_reg : after_reg;
                    cursor_next = cursor_end;
                    if (loc_mode_reg)
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = pos_reg;
                        mem_req.wdata = 16'(got_reg);
                        pos_next      = 16'(got_reg);
                        off_next      = off_reg - BB24;
                        state_next    = S_LOC_CHK;
                    end
                    else
                    begin
                        res_next   = 16'(got_reg);
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    idx_next  = idx_wrap;
                    scan_next = scan_reg + FIRST_IDX;
                end
            end

            // Hold the result until the output stage takes it
            S_RESP:
            begin
                if (resp_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            cursor_reg   <= FIRST_IDX;
            count_reg    <= MAX_FREE;
            loc_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            cursor_reg   <= cursor_next;
            count_reg    <= count_next;
            loc_mode_reg <= loc_mode_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        nv_reg     <= nv_next;
        off_reg    <= off_next;
        ext_reg    <= ext_next;
        idx_reg    <= idx_next;
        scan_reg   <= scan_next;
        got_reg    <= got_next;
        after_reg  <= after_next;
        res_reg    <= res_next;
        status_reg <= status_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/block_chain_allocation_table_core.sv =====
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  tdata: block, next_value, byte_offset, extend
//                                           tuser: operation
// m_*       out        m_tvalid / m_tready  tdata: result_block, free_blocks
//                                           tuser: status
//
// After reset a clearing pass writes every table entry, with s_tready low.
// One request at a time. Allocate runs two searches for free entries, one for the block
// to take and one for the next cursor, each visiting at most NUM_BLOCKS - 1 entries;
// an extending locate adds one allocation per new block.
// A stalled m_tready with a full output register holds the sequencer, so s_tready stays low.
`default_nettype none
`include "assert_macros.svh"

module block_chain_allocation_table_core
    import bcat_pkg::*;
#(
    parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // block[15:0], next_value[31:16], byte_offset[55:32],
                                        // extend[56], zero[63:57]
    input  wire logic [1:0]  s_tuser,   // operation[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // result_block[15:0], free_blocks[31:16]
    output logic [1:0]       m_tuser    // status[1:0]
);

    localparam int          IDX_W    = $clog2(NUM_BLOCKS);
    localparam logic [15:0] MAX_FREE = 16'(NUM_BLOCKS - 1);

    req_t        in_req;
    resp_t       resp;
    mem_req_t    mem_req;
    logic [15:0] rdata;
    logic        resp_ready;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;
    logic [1:0]  m_tuser_reg, m_tuser_next;
    logic        out_full;

    // Unpack the request
    assign in_req.operation   = s_tuser;
    assign in_req.block       = s_tdata[15:0];
    assign in_req.next_value  = s_tdata[31:16];
    assign in_req.byte_offset = s_tdata[55:32];
    assign in_req.extend      = s_tdata[56];

    bcat_ctrl #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_req     (in_req),
        .mem_req    (mem_req),
        .rdata      (rdata),
        .resp       (resp),
        .resp_ready (resp_ready)
    );

    bcat_table #(
        .DEPTH  (NUM_BLOCKS),
        .ADDR_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata   (rdata)
    );

    // Load the output register when it is empty or being drained
    assign resp_ready = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (resp.valid && resp_ready)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {resp.free_blocks, resp.result_block};
            m_tuser_next  = resp.status;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Full status on the output channel
    assign out_full = m_tvalid && (m_tuser == ST_FULL);

    // Checks
    `BCAT_ASSERT_NXT(a_busy, clk, rst_n, s_tvalid && s_tready, !s_tready, "accepted while busy")
    `BCAT_ASSERT_NXT(a_loaded, clk, rst_n, resp.valid && resp_ready, m_tvalid, "result dropped")
    `BCAT_ASSERT_IMP(a_count_range, clk, rst_n, m_tvalid, m_tdata[31:16] <= MAX_FREE, "bad count")
    `BCAT_ASSERT_IMP(a_full, clk, rst_n, out_full, m_tdata[15:0] == END_MARK, "full with block")

endmodule

`default_nettype wire
